// ----- rtl/sapl_pkg.sv -----
`default_nettype none
package sapl_pkg;

   // delay geometry
   localparam int MAX_DELAY_DEF = 1501;
   localparam int JUMP_GAP = 1500;

   // fixed field widths
   localparam int SAMPLE_W = 24;
   localparam int TARGET_W = 11;
   localparam int MIX_W = 17;

   // fixed point constants
   localparam logic [23:0] GAIN_Q24 = 24'd10368890;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;
   localparam logic [31:0] Q30_PI = 32'd3373259426;
   localparam logic [33:0] Q30_TWO_PI = 34'd6746518852;
   localparam logic signed [47:0] S24_MAX = 48'sd8388607;
   localparam logic signed [47:0] S24_MIN = -48'sd8388608;

   // register indexes
   localparam logic CSR_TARGET_LENGTH = 1'b0;
   localparam logic CSR_WET_MIX = 1'b1;

   // control from sequencer to each lane
   typedef struct packed {
      logic start;
      logic glide;
      logic clear;
   } lane_ctl_type;

   // status from each lane to merge stage
   typedef struct packed {
      logic done;
      logic signed [23:0] out;
   } lane_sts_type;

   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      logic signed [23:0] r;
      if (v > S24_MAX) r = S24_MAX[23:0];
      else if (v < S24_MIN) r = S24_MIN[23:0];
      else r = v[23:0];
      return r;
   endfunction

   // ceil(2^40 / d) for the taylor divisors; exact quotient for 32 bit numerators
   function automatic logic [39:0] recip(input logic [2:0] k, input logic want_sin);
      logic [39:0] m;
      case ({want_sin, k})
         4'b1001: m = 40'd183251937963;
         4'b1010: m = 40'd54975581389;
         4'b1011: m = 40'd26178848281;
         4'b1100: m = 40'd15270994831;
         4'b1101: m = 40'd9995560253;
         4'b1110: m = 40'd7048151461;
         4'b1111: m = 40'd5235769657;
         4'b0001: m = 40'd549755813888;
         4'b0010: m = 40'd91625968982;
         4'b0011: m = 40'd36650387593;
         4'b0100: m = 40'd19634136211;
         4'b0101: m = 40'd12216795865;
         4'b0110: m = 40'd8329633544;
         4'b0111: m = 40'd6041272681;
         default: m = 40'd0;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sapl_trig.sv -----
`default_nettype none
module sapl_trig (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        want_sin,
   input  wire logic [30:0] x,
   output logic             busy,
   output logic [30:0]      res
);
   import sapl_pkg::*;

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_SQ   = 3'd1;
   localparam logic [2:0] T_MUL  = 3'd2;
   localparam logic [2:0] T_REC  = 3'd3;
   localparam logic [2:0] T_UPD  = 3'd4;
   localparam logic [2:0] T_FIN  = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [30:0] x_ff;
   logic        sin_ff;
   logic [31:0] x2_ff;
   logic [30:0] t_ff, t_in;
   logic [2:0]  k_ff;
   logic [31:0] n_ff;
   logic [63:0] pl_ff;
   logic [39:0] ph_ff;
   logic [30:0] res_ff;

   logic [62:0] sqr;
   logic [62:0] pm;
   logic [39:0] m;
   logic [71:0] acc;
   logic [31:0] q;
   logic [61:0] pf;

   // datapath of one horner step
   assign sqr = 63'(x_ff) * 63'(x_ff) + 63'(32'h2000_0000);
   assign pm  = 63'(x2_ff) * 63'(t_ff);
   assign m   = recip(k_ff, sin_ff);
   assign acc = {ph_ff, 32'b0} + 72'(pl_ff);
   assign q   = acc[71:40];
   assign pf  = 62'(x_ff) * 62'(t_ff);
   assign t_in = (q >= 32'(Q30_ONE)) ? 31'd0 : Q30_ONE - q[30:0];

   // step sequencer
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         T_IDLE: if (start) st_in = T_SQ;
         T_SQ:   st_in = T_MUL;
         T_MUL:  st_in = T_REC;
         T_REC:  st_in = T_UPD;
         T_UPD:  st_in = (k_ff == 3'd1) ? T_FIN : T_MUL;
         T_FIN:  st_in = T_IDLE;
         default: st_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= T_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         T_IDLE: if (start) begin
            x_ff <= x;
            sin_ff <= want_sin;
            k_ff <= 3'd7;
            t_ff <= Q30_ONE;
         end
         T_SQ: x2_ff <= sqr[61:30];
         T_MUL: n_ff <= pm[61:30];
         T_REC: begin
            pl_ff <= 64'(n_ff) * 64'(m[31:0]);
            ph_ff <= 40'(n_ff) * 40'(m[39:32]);
         end
         T_UPD: begin
            t_ff <= t_in;
            k_ff <= k_ff - 3'd1;
         end
         T_FIN: res_ff <= sin_ff ? pf[60:30] : t_ff;
         default: ;
      endcase
   end

   assign busy = (st_ff != T_IDLE);
   assign res = res_ff;

endmodule
`default_nettype wire

// ----- rtl/sapl_lane.sv -----
`default_nettype none
module sapl_lane #(
   parameter int MAX_DELAY = sapl_pkg::MAX_DELAY_DEF,
   parameter int AW = $clog2(MAX_DELAY + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sapl_pkg::lane_ctl_type ctl,
   input  wire logic [AW-1:0]        src,
   input  wire logic [AW-1:0]        newml,
   input  wire logic [AW-1:0]        prev,
   input  wire logic [AW-1:0]        pos,
   input  wire logic [AW-1:0]        clr_addr,
   input  wire logic signed [23:0]   sample,
   input  wire logic [16:0]          wet_mix,
   output sapl_pkg::lane_sts_type    sts
);
   import sapl_pkg::*;

   localparam logic [3:0] L_IDLE = 4'd0;
   localparam logic [3:0] L_RDS  = 4'd1;
   localparam logic [3:0] L_AVG  = 4'd2;
   localparam logic [3:0] L_RDP  = 4'd3;
   localparam logic [3:0] L_CAP  = 4'd4;
   localparam logic [3:0] L_WSIN = 4'd5;
   localparam logic [3:0] L_MG1  = 4'd6;
   localparam logic [3:0] L_V    = 4'd7;
   localparam logic [3:0] L_WR   = 4'd8;
   localparam logic [3:0] L_W    = 4'd9;
   localparam logic [3:0] L_RED  = 4'd10;
   localparam logic [3:0] L_RED2 = 4'd11;
   localparam logic [3:0] L_WCOS = 4'd12;
   localparam logic [3:0] L_MIX  = 4'd13;
   localparam logic [3:0] L_OUT  = 4'd14;

   // delay line memory
   logic [23:0] mem [0:MAX_DELAY];
   logic [23:0] rd_data_ff;
   logic        rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [23:0] wr_data;

   logic [3:0]  st_ff, st_in;
   logic signed [23:0] e0_ff, dprev_ff, sl_ff, v_ff, w_ff, out_ff;
   logic signed [48:0] gp_ff, gv_ff;
   logic [33:0] a1_ff;
   logic        far_ff;
   logic signed [27:0] wet_ff;
   logic signed [41:0] pd_ff;
   logic signed [45:0] pw_ff;
   logic        done_ff;

   // trig unit
   logic        trig_start, trig_sin, trig_busy;
   logic [30:0] trig_x, trig_res;

   // combinational datapath
   logic signed [24:0] avg_sum;
   logic [23:0]  mag_in;
   logic [31:0]  a_in;
   logic [30:0]  xs;
   logic [21:0]  s_rnd;
   logic signed [23:0] sl_in;
   logic signed [48:0] gp_r, gv_r;
   logic signed [23:0] v_in, w_in, rd2;
   logic [23:0]  mag_w;
   logic [33:0]  aw, a1_in, a2;
   logic         far_in;
   logic [33:0]  xc;
   logic [31:0]  c;
   logic [21:0]  c20;
   logic signed [25:0] shaped;
   logic [16:0]  dry_w;
   logic signed [46:0] mix_sum;
   logic signed [23:0] out_in;

   always_comb begin
      avg_sum = 25'(e0_ff) + 25'($signed(rd_data_ff));
      mag_in = sample[23] ? 24'(-sample) : 24'(sample);
      a_in = {mag_in, 8'b0};
      xs = (a_in > Q30_HALF_PI) ? 31'(Q30_PI - a_in) : a_in[30:0];
      s_rnd = 22'((32'(trig_res) + 32'd512) >> 10);
      sl_in = (sample > 24'sd0) ? $signed(24'(s_rnd)) : -$signed(24'(s_rnd));
      gp_r = gp_ff + 49'sd8388608;
      gv_r = gv_ff + 49'sd8388608;
      v_in = sat24(48'(sl_ff) - 48'($signed(gp_r[48:24])));
      rd2 = (prev == pos) ? v_ff : dprev_ff;
      w_in = sat24(48'($signed(gv_r[48:24])) + 48'(rd2));
      mag_w = w_ff[23] ? 24'(-w_ff) : 24'(w_ff);
      aw = {mag_w, 10'b0};
      a1_in = (aw >= Q30_TWO_PI) ? aw - Q30_TWO_PI : aw;
      a2 = (a1_ff > 34'(Q30_PI)) ? Q30_TWO_PI - a1_ff : a1_ff;
      far_in = (a2 > 34'(Q30_HALF_PI));
      xc = far_in ? 34'(Q30_PI) - a2 : a2;
      c = far_ff ? 32'(Q30_ONE) + 32'(trig_res) : 32'(Q30_ONE) - 32'(trig_res);
      c20 = 22'((33'(c) + 33'd512) >> 10);
      shaped = (w_ff > 24'sd0) ? 26'(w_ff) - $signed(26'(c20))
                               : 26'(w_ff) + $signed(26'(c20));
      dry_w = 17'h10000 - {1'b0, wet_mix[15:0]};
      mix_sum = 47'(pd_ff) + 47'(pw_ff) + 47'sd32768;
      out_in = wet_mix[16] ? sat24(48'(wet_ff)) : sat24(48'($signed(mix_sum[46:16])));
   end

   // trig unit is shared by the soft clip and the shaper
   assign trig_start = (st_ff == L_IDLE && ctl.start) || (st_ff == L_RED2);
   assign trig_sin = (st_ff == L_IDLE);
   assign trig_x = (st_ff == L_IDLE) ? xs : xc[30:0];

   sapl_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .start    (trig_start),
      .want_sin (trig_sin),
      .x        (trig_x),
      .busy     (trig_busy),
      .res      (trig_res)
   );

   // memory port selection
   always_comb begin
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      case (st_ff)
         L_IDLE: if (ctl.start) begin
            rd_en = 1'b1;
         end
         L_RDS: begin
            rd_en = 1'b1;
            rd_addr = src;
         end
         L_AVG: if (ctl.glide) begin
            wr_en = 1'b1;
            wr_addr = newml;
            wr_data = avg_sum[24:1];
         end
         L_RDP: begin
            rd_en = 1'b1;
            rd_addr = prev;
         end
         L_WR: begin
            wr_en = 1'b1;
            wr_addr = pos;
            wr_data = v_ff;
         end
         default: ;
      endcase
      if (ctl.clear) begin
         wr_en = 1'b1;
         wr_addr = clr_addr;
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // lane sequencer
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         L_IDLE: if (ctl.start) st_in = L_RDS;
         L_RDS:  st_in = L_AVG;
         L_AVG:  st_in = L_RDP;
         L_RDP:  st_in = L_CAP;
         L_CAP:  st_in = L_WSIN;
         L_WSIN: if (!trig_busy) st_in = L_MG1;
         L_MG1:  st_in = L_V;
         L_V:    st_in = L_WR;
         L_WR:   st_in = L_W;
         L_W:    st_in = L_RED;
         L_RED:  st_in = L_RED2;
         L_RED2: st_in = L_WCOS;
         L_WCOS: if (!trig_busy) st_in = L_MIX;
         L_MIX:  st_in = L_OUT;
         L_OUT:  st_in = L_IDLE;
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == L_IDLE && ctl.start) done_ff <= 1'b0;
         else if (st_ff == L_OUT) done_ff <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (st_ff)
         L_RDS:  e0_ff <= rd_data_ff;
         L_CAP:  dprev_ff <= rd_data_ff;
         L_WSIN: sl_ff <= sl_in;
         L_MG1:  gp_ff <= dprev_ff * $signed({1'b0, GAIN_Q24});
         L_V:    v_ff <= v_in;
         L_WR:   gv_ff <= v_ff * $signed({1'b0, GAIN_Q24});
         L_W:    w_ff <= w_in;
         L_RED:  a1_ff <= a1_in;
         L_RED2: far_ff <= far_in;
         L_WCOS: wet_ff <= 28'(shaped) <<< 2;
         L_MIX: begin
            pd_ff <= sample * $signed({1'b0, dry_w});
            pw_ff <= wet_ff * $signed({1'b0, wet_mix});
         end
         L_OUT:  out_ff <= out_in;
         default: ;
      endcase
   end

   assign sts.done = done_ff;
   assign sts.out = out_ff;

endmodule
`default_nettype wire

// ----- rtl/stereo_allpass_length_glide.sv -----
`default_nettype none
// Stereo allpass with a gliding delay length. For each sample pair beat, each
// channel lane runs a sin and then a cos through its one shared seven-step
// Taylor unit, around a handful of delay-memory reads and writes. A new
// pair is taken once the previous one has left the lanes; a finished result
// waits in the output register meanwhile. After reset both delay memories are
// swept to zero, one entry per cycle, over all MAX_DELAY+1 entries (1502 by
// default); req_stall is high during that sweep, while csr writes are taken
// as usual.
module stereo_allpass_length_glide #(
   parameter int MAX_DELAY = sapl_pkg::MAX_DELAY_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [23:0] req_left_sample,
   input  wire logic signed [23:0] req_right_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_left_out,
   output logic signed [23:0]      rsp_right_out,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_index,
   input  wire logic [16:0]        csr_wdata
);
   import sapl_pkg::*;

   localparam int AW = $clog2(MAX_DELAY + 1);
   localparam int TW = (AW > TARGET_W) ? AW : TARGET_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PLAN = 2'd1;
   localparam logic [1:0] S_RUN  = 2'd2;

   logic [1:0]  st_ff;
   logic        clearing_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [10:0] target_ff;
   logic [16:0] wet_ff;
   logic [AW-1:0] active_ff, tap_ff;
   logic        start_ff, glide_ff;
   logic [AW-1:0] src_ff, newml_ff, prev_ff, pos_ff;
   logic signed [23:0] samp_l_ff, samp_r_ff;
   logic        rsp_valid_ff;
   logic signed [23:0] out_l_ff, out_r_ff;

   logic        accept, deliver;
   lane_ctl_type ctl;
   lane_sts_type sts_l, sts_r;

   // glide planning
   logic [AW-1:0] tgt, ml, pos, gap, ml_j, newml, src, prev;
   logic          grow, shrink;

   always_comb begin
      tgt = (TW'(target_ff) > TW'(MAX_DELAY)) ? AW'(MAX_DELAY) : AW'(target_ff);
      ml = (active_ff > AW'(MAX_DELAY)) ? AW'(MAX_DELAY) : active_ff;
      pos = (tap_ff > AW'(MAX_DELAY)) ? AW'(MAX_DELAY) : tap_ff;
      gap = (ml > tgt) ? ml - tgt : tgt - ml;
      ml_j = (32'(gap) > 32'(JUMP_GAP)) ? tgt : ml;
      grow = (ml_j < tgt);
      shrink = (ml_j > tgt);
      newml = grow ? ml_j + AW'(1) : (shrink ? ml_j - AW'(1) : ml_j);
      src = grow ? ml_j : newml;
      prev = (pos == '0 || (pos - AW'(1)) > newml) ? newml : pos - AW'(1);
   end

   assign req_stall = clearing_ff || (st_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign deliver = (st_ff == S_RUN) && !start_ff && sts_l.done && sts_r.done
                    && (!rsp_valid_ff || !rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         wet_ff <= 17'h10000;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET_LENGTH: target_ff <= csr_wdata[10:0];
            CSR_WET_MIX: wet_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clr_addr_ff == AW'(MAX_DELAY)) clearing_ff <= 1'b0;
         else clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // sequencer and delay state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         start_ff <= 1'b0;
         glide_ff <= 1'b0;
         active_ff <= '0;
         tap_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (accept) st_ff <= S_PLAN;
            S_PLAN: begin
               glide_ff <= grow || shrink;
               active_ff <= newml;
               tap_ff <= prev;
               start_ff <= 1'b1;
               st_ff <= S_RUN;
            end
            S_RUN: if (deliver) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
         if (deliver) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         samp_l_ff <= req_left_sample;
         samp_r_ff <= req_right_sample;
      end
      if (st_ff == S_PLAN) begin
         src_ff <= src;
         newml_ff <= newml;
         prev_ff <= prev;
         pos_ff <= pos;
      end
      if (deliver) begin
         out_l_ff <= sts_l.out;
         out_r_ff <= sts_r.out;
      end
   end

   assign ctl.start = start_ff;
   assign ctl.glide = glide_ff;
   assign ctl.clear = clearing_ff;

   sapl_lane #(.MAX_DELAY(MAX_DELAY), .AW(AW)) u_lane_l (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .src      (src_ff),
      .newml    (newml_ff),
      .prev     (prev_ff),
      .pos      (pos_ff),
      .clr_addr (clr_addr_ff),
      .sample   (samp_l_ff),
      .wet_mix  (wet_ff),
      .sts      (sts_l)
   );

   sapl_lane #(.MAX_DELAY(MAX_DELAY), .AW(AW)) u_lane_r (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .src      (src_ff),
      .newml    (newml_ff),
      .prev     (prev_ff),
      .pos      (pos_ff),
      .clr_addr (clr_addr_ff),
      .sample   (samp_r_ff),
      .wet_mix  (wet_ff),
      .sts      (sts_r)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out = out_l_ff;
   assign rsp_right_out = out_r_ff;

endmodule
`default_nettype wire

// ----- rtl/sapl_check.sv -----
`default_nettype none
module sapl_check (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [23:0] rsp_left_out,
   input wire logic signed [23:0] rsp_right_out
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_out)
                                 && $stable(rsp_right_out))
      else $error("rsp beat changed while stalled");

   // reset empties the output and starts the clearing sweep
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("reset did not clear output or block input");

   // one pair at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second pair taken right after accept");

   // no result appears right after an accept
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared right after accept");

endmodule

bind stereo_allpass_length_glide sapl_check u_sapl_check (.*);
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
   import sapl_pkg::*;

   localparam int DEPTH = 1502;
   localparam int LIMIT_CYCLES = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_left_sample = '0;
   logic signed [23:0] req_right_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_left_out;
   logic signed [23:0] rsp_right_out;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_TARGET_LENGTH;
   logic [16:0] csr_wdata = '0;

   stereo_allpass_length_glide dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model state for the allpass delay
   longint left_line [DEPTH];
   longint right_line [DEPTH];
   int unsigned cur_length;
   int unsigned write_pos;
   int unsigned want_length;
   int unsigned wet_frac;

   logic signed [23:0] left_expect_q [$];
   logic signed [23:0] right_expect_q [$];

   int unsigned errors = 0;
   int unsigned pairs_sent = 0;
   int unsigned pairs_checked = 0;
   int unsigned cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // divide by 2^sh rounding half up
   function automatic longint round_down_shift(longint p, int sh);
      longint bias;
      bias = longint'(1) <<< 48;
      return ((p + bias + (longint'(1) <<< (sh - 1))) >>> sh) - (bias >>> sh);
   endfunction

   function automatic longint times_gain(longint x);
      return round_down_shift(x * 64'sd10368890, 24);
   endfunction

   function automatic longint floor_half(longint s);
      return s >= 0 ? s / 2 : -((-s + 1) / 2);
   endfunction

   // taylor series in q30 on [0, pi/2]
   function automatic longint unsigned taylor_q30(longint unsigned x, bit want_sin);
      longint unsigned x2, t, dv, p;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t = 64'd1 << 30;
      for (int k = 7; k >= 1; k--) begin
         dv = want_sin ? longint'(2 * k) * longint'(2 * k + 1)
                       : longint'(2 * k - 1) * longint'(2 * k);
         p = (x2 * t) / (dv << 30);
         t = (p >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - p;
      end
      return want_sin ? (x * t) >> 30 : t;
   endfunction

   function automatic longint sine_clip(longint x);
      longint unsigned a;
      longint s;
      a = longint'(x < 0 ? -x : x) << 8;
      if (a > 64'd1686629713) a = 64'd3373259426 - a;
      s = longint'((taylor_q30(a, 1'b1) + 512) >> 10);
      return x > 0 ? s : -s;
   endfunction

   function automatic longint cos_shape(longint w);
      longint unsigned a, c;
      longint c20;
      a = longint'(w < 0 ? -w : w) << 10;
      if (a >= 64'd6746518852) a -= 64'd6746518852;
      if (a > 64'd3373259426) a = 64'd6746518852 - a;
      if (a <= 64'd1686629713) c = (64'd1 << 30) - taylor_q30(a, 1'b0);
      else c = (64'd1 << 30) + taylor_q30(64'd3373259426 - a, 1'b0);
      c20 = longint'((c + 512) >> 10);
      return w > 0 ? w - c20 : w + c20;
   endfunction

   function automatic longint wet_dry(longint dry, longint wet_sig);
      if (wet_frac >= 65536) return wet_sig;
      return round_down_shift(dry * (65536 - wet_frac) + wet_sig * wet_frac, 16);
   endfunction

   // advance the allpass model by one pair and queue the expected output
   task automatic predict_allpass(input logic signed [23:0] l_in,
                                  input logic signed [23:0] r_in);
      longint dl, dr, sl, sr, vl, vr, wl, wr;
      int unsigned tgt, ml, pos, gap, prev;
      dl = l_in;
      dr = r_in;
      sl = sine_clip(dl);
      sr = sine_clip(dr);
      tgt = want_length > 1501 ? 1501 : want_length;
      ml = cur_length > 1501 ? 1501 : cur_length;
      pos = write_pos > 1501 ? 1501 : write_pos;
      gap = ml > tgt ? ml - tgt : tgt - ml;
      if (gap > JUMP_GAP) ml = tgt;
      if (ml < tgt) begin
         ml++;
         left_line[ml] = floor_half(left_line[0] + left_line[ml - 1]);
         right_line[ml] = floor_half(right_line[0] + right_line[ml - 1]);
      end
      if (ml > tgt) begin
         ml--;
         left_line[ml] = floor_half(left_line[0] + left_line[ml]);
         right_line[ml] = floor_half(right_line[0] + right_line[ml]);
      end
      prev = (pos == 0 || pos - 1 > ml) ? ml : pos - 1;
      vl = clamp24(sl - times_gain(left_line[prev]));
      vr = clamp24(sr - times_gain(right_line[prev]));
      left_line[pos] = vl;
      right_line[pos] = vr;
      pos = prev;
      wl = clamp24(times_gain(vl) + left_line[pos]);
      wr = clamp24(times_gain(vr) + right_line[pos]);
      cur_length = ml;
      write_pos = pos;
      left_expect_q.push_back(24'(clamp24(wet_dry(dl, cos_shape(wl) * 4))));
      right_expect_q.push_back(24'(clamp24(wet_dry(dr, cos_shape(wr) * 4))));
   endtask

   // send one pair beat and predict it; valid stays high until the next idle gap
   task automatic send_pair(input logic signed [23:0] l_in, input logic signed [23:0] r_in);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_sample <= l_in;
      req_right_sample <= r_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_allpass(l_in, r_in);
      pairs_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [16:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TARGET_LENGTH) want_length = val[10:0];
      else wet_frac = val;
      @(posedge clock);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (left_expect_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(5))
         0: return 24'sh7fffff;
         1: return -24'sh800000;
         2: return 24'($signed($urandom_range(2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (left_expect_q.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            if (rsp_left_out !== left_expect_q[0]) begin
               $error("left_out expected %0d got %0d", left_expect_q[0], rsp_left_out);
               errors++;
            end
            if (rsp_right_out !== right_expect_q[0]) begin
               $error("right_out expected %0d got %0d", right_expect_q[0], rsp_right_out);
               errors++;
            end
            void'(left_expect_q.pop_front());
            void'(right_expect_q.pop_front());
            pairs_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > LIMIT_CYCLES) begin
         $display("stereo_allpass_length_glide verification failed");
         $finish;
      end
   end

   task automatic test_directed_edges;
      logic signed [23:0] vals [8];
      vals = '{24'sh0, 24'sh7fffff, -24'sh800000, 24'sh1, -24'sh1,
               24'sh19_2000, -24'sh64_8000, 24'sh55aaaa};
      write_reg(CSR_TARGET_LENGTH, 17'd4);
      write_reg(CSR_WET_MIX, 17'd65536);
      foreach (vals[i]) send_pair(vals[i], vals[7 - i]);
      for (int i = 0; i < 8; i++) send_pair(24'sh7fffff, -24'sh800000);
      drain_results();
      // target above range, clamped to the longest delay
      write_reg(CSR_TARGET_LENGTH, 17'd2047);
      for (int i = 0; i < 4; i++) send_pair(rand_sample(), rand_sample());
      drain_results();
      write_reg(CSR_WET_MIX, 17'd0);
      write_reg(CSR_TARGET_LENGTH, 17'd0);
      for (int i = 0; i < 4; i++) send_pair(rand_sample(), rand_sample());
      drain_results();
   endtask

   task automatic test_random_glide(input int n, input int idle, input int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      write_reg(CSR_TARGET_LENGTH, 17'($urandom_range(1)) ? 17'($urandom_range(40))
                                                           : 17'($urandom_range(2047)));
      case ($urandom_range(3))
         0: write_reg(CSR_WET_MIX, 17'd0);
         1: write_reg(CSR_WET_MIX, 17'h1ffff);
         default: write_reg(CSR_WET_MIX, 17'($urandom_range(65536)));
      endcase
      for (int i = 0; i < n; i++) send_pair(rand_sample(), rand_sample());
      drain_results();
   endtask

   initial begin
      foreach (left_line[i]) begin
         left_line[i] = 0;
         right_line[i] = 0;
      end
      cur_length = 0;
      write_pos = 0;
      want_length = 0;
      wet_frac = 65536;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: test_random_glide(80, 0, 0);
            1: test_random_glide(80, 67, 0);
            2: test_random_glide(80, 0, 67);
            default: test_random_glide(80, 33, 33);
         endcase
      end
      $display("sent %0d sample pairs, checked %0d results", pairs_sent, pairs_checked);
      $display("covered glide, length jumps, wet/dry extremes and handshake stalls");
      if (errors == 0) $display("stereo_allpass_length_glide verification clean");
      else $display("stereo_allpass_length_glide verification failed");
      $finish;
   end
endmodule
`default_nettype wire
